// ===== hdl/double_ended_queue_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Same-cycle and next-cycle implication checks on clock / reset.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue.
// ---------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   localparam int unsigned DEFAULT_DEPTH = 16;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned ACTION_W      = 2;
   localparam int unsigned STATUS_W      = 2;
   // action + value, padded to whole bytes
   localparam int unsigned REQ_BITS      = ACTION_W + WORD_W;
   localparam int unsigned REQ_W         = ((REQ_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic exec;    // apply the accepted request to indices and store
      logic fetch;   // read front and rear words into the result registers
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/dq_datapath.sv =====
// ---------------------------------------------------------------------------
// dq_datapath
// Ring store, head/tail indices, element count and result registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_top_assert.svh"

module dq_datapath
   import dq_pkg::*;
#(
   parameter  int unsigned DEPTH = DEFAULT_DEPTH,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire action_type               req_action,
   input  wire logic signed [WORD_W-1:0] req_value,
   output status_type                    rsp_status,
   output logic [CW-1:0]                 rsp_count,
   output logic                          rsp_is_empty,
   output logic signed [WORD_W-1:0]      rsp_front_value,
   output logic signed [WORD_W-1:0]      rsp_rear_value
);

   localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : AW'(i + 1'b1);
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
      return (i == '0) ? LAST_IDX : AW'(i - 1'b1);
   endfunction

   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   status_type            status_ff, status_in;
   logic [WORD_W-1:0]     store [DEPTH];
   logic [WORD_W-1:0]     front_rd_ff, rear_rd_ff;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  is_full, is_empty;

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      if (cmd.exec) begin
         status_in = ST_OK;
         unique case (req_action)
            ACT_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  head_in  = idx_dec(head_ff);
                  wr_en    = 1'b1;
                  wr_addr  = idx_dec(head_ff);
                  count_in = CW'(count_ff + 1'b1);
               end
            end
            ACT_PUSH_REAR: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  tail_in  = idx_inc(tail_ff);
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  count_in = CW'(count_ff + 1'b1);
               end
            end
            ACT_POP_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  head_in  = idx_inc(head_ff);
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            ACT_POP_REAR: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  tail_in  = idx_dec(tail_ff);
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         status_ff <= ST_OK;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // ring store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         front_rd_ff <= store[head_ff];
         rear_rd_ff  <= store[idx_dec(tail_ff)];
      end
   end

   // empty deque reports zero words
   assign rsp_status      = status_ff;
   assign rsp_count       = count_ff;
   assign rsp_is_empty    = is_empty;
   assign rsp_front_value = is_empty ? '0 : front_rd_ff;
   assign rsp_rear_value  = is_empty ? '0 : rear_rd_ff;

   `DQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_CNT, "count exceeds depth")
   `DQ_ASSERT_NOW(a_ring_closed, (count_ff == '0) || (count_ff == FULL_CNT),
                  head_ff == tail_ff, "head and tail disagree at empty or full")
   `DQ_ASSERT_NEXT(a_refused_holds, cmd.exec && (status_in != ST_OK),
                   $stable(count_ff) && $stable(head_ff) && $stable(tail_ff),
                   "refused request changed state")

endmodule

`default_nettype wire

// ===== hdl/dq_controller.sv =====
// ---------------------------------------------------------------------------
// dq_controller
// Request sequencer: accept, read back front/rear, present result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_top_assert.svh"

module dq_controller
   import dq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `DQ_ASSERT_NOW(a_one_side, 1'b1, !(req_tready && rsp_tvalid), "ready and valid together")
   `DQ_ASSERT_NEXT(a_no_overlap, req_tvalid && req_tready, !req_tready,
                   "second request taken before result")
   `DQ_ASSERT_NEXT(a_back_to_idle, rsp_tvalid && rsp_tready, req_tready,
                   "not ready after result taken")

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_top.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit words in a ring store.
// ---------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                           | tuser
//  req_    | in  | action[1:0], value[33:2], zero pad to 40 bits       | none
//  rsp_    | out | status, count, is_empty, front_value, rear_value    | none
//
//  Sequence: a request is accepted and applied, then the store is read, then
//  the result is shown; the next request is taken the cycle after the result
//  is consumed. The separate store read step is set by the registered
//  two-address read of the ring store.
//  Reset: synchronous, clears indices, count and the sequencer; store is
//  not cleared (only live slots are ever reported).
//  Stalls: a held result blocks new requests until rsp_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top
   import dq_pkg::*;
#(
   parameter  int unsigned DEPTH    = DEFAULT_DEPTH,
   localparam int unsigned CW       = $clog2(DEPTH + 1),
   localparam int unsigned RSP_BITS = STATUS_W + CW + 1 + 2 * WORD_W,
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request: action[1:0], value[33:2], zeros above
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // result: status[1:0], count[CW+1:2], is_empty, front_value, rear_value,
   // zeros above
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   cmd_type                  cmd;
   action_type               req_action;
   logic signed [WORD_W-1:0] req_value;
   status_type               rsp_status;
   logic [CW-1:0]            rsp_count;
   logic                     rsp_is_empty;
   logic signed [WORD_W-1:0] rsp_front_value;
   logic signed [WORD_W-1:0] rsp_rear_value;

   // unpack request fields
   assign req_action = action_type'(req_tdata[ACTION_W-1:0]);
   assign req_value  = req_tdata[ACTION_W +: WORD_W];

   // sequencer: one request in flight, result held until taken
   dq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // ring store, indices, count and result registers
   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value)
   );

   // pack result, zero-filled to whole bytes
   assign rsp_tdata = RSP_W'({rsp_rear_value, rsp_front_value, rsp_is_empty,
                              rsp_count, rsp_status});

endmodule

`default_nettype wire
